@@ sv/pfl_pkg.sv @@
package pfl_pkg;

  localparam int MAX_BUFFER_BYTES = 65536;

  localparam int OFFSET_W = 16;
  localparam int LENGTH_W = 64;
  localparam int FIELD_W  = 32;
  localparam int WTYPE_W  = 3;
  localparam int CFG_W    = 32;

  // varint groups of 7 bits, ten at most
  localparam int VARINT_GROUPS = 10;
  localparam int GROUP_W       = 4;
  localparam logic [GROUP_W-1:0] VARINT_LAST_GROUP = GROUP_W'(VARINT_GROUPS - 1);

  // wire types
  localparam logic [WTYPE_W-1:0] WT_VARINT = 3'd0;
  localparam logic [WTYPE_W-1:0] WT_I64    = 3'd1;
  localparam logic [WTYPE_W-1:0] WT_LEN    = 3'd2;
  localparam logic [WTYPE_W-1:0] WT_I32    = 3'd5;

  // configuration register indexes
  localparam logic CFG_TARGET_FIELD     = 1'b0;
  localparam logic CFG_TARGET_WIRE_TYPE = 1'b1;

  localparam logic [FIELD_W-1:0] TARGET_FIELD_RESET     = 32'd1;
  localparam logic [WTYPE_W-1:0] TARGET_WIRE_TYPE_RESET = WT_LEN;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_VALUE,
    PH_LEN,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [LENGTH_W-1:0]   acc;
    logic [GROUP_W-1:0]    group;
    logic                  num_match;
    logic [LENGTH_W-1:0]   skip;
    logic [OFFSET_W-1:0]   match_offset;
  } pfl_state_t;

  localparam pfl_state_t STATE_IDLE = '{
    phase:        PH_KEY,
    acc:          '0,
    group:        '0,
    num_match:    1'b0,
    skip:         '0,
    match_offset: '0
  };

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] content_offset;
    logic [LENGTH_W-1:0] field_length;
  } pfl_result_t;

endpackage

@@ sv/pfl_varint.sv @@
module pfl_varint (
  input  logic [pfl_pkg::LENGTH_W-1:0] acc,
  input  logic [pfl_pkg::GROUP_W-1:0]  group,
  input  logic [7:0]                   data_byte,
  output logic [pfl_pkg::LENGTH_W-1:0] acc_next,
  output logic                         complete,
  output logic                         overlong
);

  logic [pfl_pkg::LENGTH_W-1:0] shifted;

  // place the 7 payload bits at their group; bits past 63 drop off
  always_comb begin
    shifted = '0;
    for (int i = 0; i < pfl_pkg::VARINT_GROUPS; i++) begin
      if (group == pfl_pkg::GROUP_W'(i)) begin
        shifted = pfl_pkg::LENGTH_W'(data_byte[6:0]) << (7 * i);
      end
    end
  end

  assign acc_next = acc | shifted;
  assign complete = !data_byte[7];
  assign overlong = data_byte[7] && (group == pfl_pkg::VARINT_LAST_GROUP);

endmodule

@@ sv/pfl_step.sv @@
module pfl_step (
  input  pfl_pkg::pfl_state_t                  state,
  input  logic [7:0]                           data_byte,
  input  logic                                 last_byte,
  input  logic                                 at_limit,
  input  logic [pfl_pkg::OFFSET_W-1:0]         next_offset,
  input  logic [pfl_pkg::FIELD_W-1:0]          seek_field,
  input  logic [pfl_pkg::WTYPE_W-1:0]          target_wire_type,
  output pfl_pkg::pfl_state_t                  state_next,
  output logic                                 res_valid,
  output pfl_pkg::pfl_result_t                 result
);

  logic [pfl_pkg::LENGTH_W-1:0] acc_new;
  logic                         complete;
  logic                         overlong;
  logic [pfl_pkg::WTYPE_W-1:0]  wt;
  logic [pfl_pkg::FIELD_W-1:0]  fnum;
  logic busy, limit_miss, in_varint, vint_bad, vint_end, key_bad;
  logic value_hit, len_zero_hit, skip_end, skip_hit, hit, miss;

  pfl_varint u_varint (
    .acc       (state.acc),
    .group     (state.group),
    .data_byte (data_byte),
    .acc_next  (acc_new),
    .complete  (complete),
    .overlong  (overlong)
  );

  assign wt   = acc_new[pfl_pkg::WTYPE_W-1:0];
  assign fnum = acc_new[pfl_pkg::WTYPE_W +: pfl_pkg::FIELD_W];

  assign busy       = (state.phase != pfl_pkg::PH_DONE);
  assign limit_miss = busy && at_limit;
  assign in_varint  = !limit_miss && ((state.phase == pfl_pkg::PH_KEY) ||
                      (state.phase == pfl_pkg::PH_VALUE) || (state.phase == pfl_pkg::PH_LEN));
  assign vint_bad   = in_varint && overlong;
  assign vint_end   = in_varint && complete;
  assign key_bad    = vint_end && (state.phase == pfl_pkg::PH_KEY) &&
                      !((wt == pfl_pkg::WT_VARINT) || (wt == pfl_pkg::WT_LEN) ||
                        (wt == pfl_pkg::WT_I64) || (wt == pfl_pkg::WT_I32));
  assign value_hit    = vint_end && (state.phase == pfl_pkg::PH_VALUE) && state.num_match;
  assign len_zero_hit = vint_end && (state.phase == pfl_pkg::PH_LEN) &&
                        (acc_new == '0) && state.num_match;
  assign skip_end   = !limit_miss && (state.phase == pfl_pkg::PH_SKIP) &&
                      (state.skip == pfl_pkg::LENGTH_W'(1));
  assign skip_hit   = skip_end && state.num_match;
  assign hit        = value_hit || len_zero_hit || skip_hit;
  assign miss       = limit_miss || vint_bad || key_bad;

  // next state
  always_comb begin
    state_next = state;
    if (limit_miss) begin
      state_next.phase = pfl_pkg::PH_DONE;
    end else begin
      unique case (state.phase)
        pfl_pkg::PH_KEY, pfl_pkg::PH_VALUE, pfl_pkg::PH_LEN: begin
          state_next.acc = acc_new;
          if (overlong) begin
            state_next.phase = pfl_pkg::PH_DONE;
          end else if (!complete) begin
            state_next.group = state.group + pfl_pkg::GROUP_W'(1);
          end else if (state.phase == pfl_pkg::PH_KEY) begin
            state_next.num_match = (fnum == seek_field) && (wt == target_wire_type);
            state_next.acc       = '0;
            state_next.group     = '0;
            unique case (wt)
              pfl_pkg::WT_VARINT: begin
                state_next.match_offset = next_offset;
                state_next.phase        = pfl_pkg::PH_VALUE;
              end
              pfl_pkg::WT_LEN: begin
                state_next.phase = pfl_pkg::PH_LEN;
              end
              pfl_pkg::WT_I64: begin
                state_next.num_match = 1'b0;
                state_next.skip      = pfl_pkg::LENGTH_W'(8);
                state_next.phase     = pfl_pkg::PH_SKIP;
              end
              pfl_pkg::WT_I32: begin
                state_next.num_match = 1'b0;
                state_next.skip      = pfl_pkg::LENGTH_W'(4);
                state_next.phase     = pfl_pkg::PH_SKIP;
              end
              default: begin
                state_next.phase = pfl_pkg::PH_DONE;
              end
            endcase
          end else if (state.phase == pfl_pkg::PH_VALUE) begin
            if (state.num_match) begin
              state_next.phase = pfl_pkg::PH_DONE;
            end else begin
              state_next.acc   = '0;
              state_next.group = '0;
              state_next.phase = pfl_pkg::PH_KEY;
            end
          end else begin
            // length varint done: content starts at the next byte
            state_next.match_offset = next_offset;
            if (acc_new == '0) begin
              if (state.num_match) begin
                state_next.phase = pfl_pkg::PH_DONE;
              end else begin
                state_next.acc   = '0;
                state_next.group = '0;
                state_next.phase = pfl_pkg::PH_KEY;
              end
            end else begin
              state_next.skip  = acc_new;
              state_next.phase = pfl_pkg::PH_SKIP;
            end
          end
        end
        pfl_pkg::PH_SKIP: begin
          state_next.skip = state.skip - pfl_pkg::LENGTH_W'(1);
          if (skip_end) begin
            if (state.num_match) begin
              state_next.phase = pfl_pkg::PH_DONE;
            end else begin
              state_next.acc   = '0;
              state_next.group = '0;
              state_next.phase = pfl_pkg::PH_KEY;
            end
          end
        end
        pfl_pkg::PH_DONE: begin
          state_next = state;
        end
        default: begin
          state_next = state;
        end
      endcase
    end
    if (last_byte) begin
      state_next = pfl_pkg::STATE_IDLE;
    end
  end

  // result
  always_comb begin
    res_valid = busy && (hit || miss || last_byte);
    result    = '0;
    if (hit) begin
      result.found = 1'b1;
      if (len_zero_hit) begin
        result.content_offset = next_offset;
      end else begin
        result.content_offset = state.match_offset;
      end
      if (value_hit) begin
        result.field_length = acc_new;
      end else if (skip_hit) begin
        result.field_length = state.acc;
      end
    end
  end

endmodule

@@ sv/protobuf_field_locator.sv @@
// Protobuf field locator: takes one byte of a wire-format buffer per cycle
// and reports, once per buffer, the first field whose number and wire type
// equal seek_field and target_wire_type. A hit gives the content offset
// and either the decoded value (varint) or the content length (delimited);
// fixed 64/32-bit fields are skipped and never match. Group or reserved
// wire types, a varint longer than ten bytes, a buffer ending inside an
// element, or a byte at index MAX_BUFFER_BYTES or beyond give found = 0.
// Bytes after the answer are dropped until last_byte, which always closes
// the buffer and returns the scan to its start. Throughput is one byte per
// cycle: the whole decode of a byte is one pass through the step logic
// into the scan state registers, and the answer is registered on the clock
// edge that accepts the deciding byte. A skid entry behind the result
// register lets bytes keep flowing while a request waits on result_stall;
// byte_stall rises only once it is occupied. Configuration must be written
// only while no buffer is in flight; the block does not enforce this.
module protobuf_field_locator #(
  parameter int MAX_BUFFER_BYTES = pfl_pkg::MAX_BUFFER_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  // byte channel
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         found,
  output logic [pfl_pkg::OFFSET_W-1:0] content_offset,
  output logic [pfl_pkg::LENGTH_W-1:0] field_length,
  // configuration write port
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [pfl_pkg::CFG_W-1:0]    cfg_data
);

  // position saturates at the buffer limit
  localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);

  // configuration registers
  logic [pfl_pkg::FIELD_W-1:0] seek_field;
  logic [pfl_pkg::WTYPE_W-1:0] target_wire_type;

  // scan state
  pfl_pkg::pfl_state_t state;
  pfl_pkg::pfl_state_t state_next;
  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_next;
  logic [POS_W-1:0]    pos_inc;
  logic [31:0]         pos_wide;
  logic                at_limit;

  // step outputs
  logic                 step_valid;
  pfl_pkg::pfl_result_t step_result;

  // result register and skid entry
  pfl_pkg::pfl_result_t out_data;
  pfl_pkg::pfl_result_t skid_data;
  logic                 skid_valid;

  logic accept;
  logic push;
  logic pop;

  assign accept = byte_valid && !byte_stall;
  assign push   = accept && step_valid;
  assign pop    = result_valid && !result_stall;

  assign byte_stall = skid_valid;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      seek_field       <= pfl_pkg::TARGET_FIELD_RESET;
      target_wire_type <= pfl_pkg::TARGET_WIRE_TYPE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pfl_pkg::CFG_TARGET_FIELD:     seek_field       <= cfg_data[pfl_pkg::FIELD_W-1:0];
        pfl_pkg::CFG_TARGET_WIRE_TYPE: target_wire_type <= cfg_data[pfl_pkg::WTYPE_W-1:0];
      endcase
    end
  end

  // byte position and offset of the byte after this one, mod 2^16
  assign at_limit = (pos == POS_W'(MAX_BUFFER_BYTES));
  assign pos_inc  = pos + POS_W'(1);
  assign pos_wide = 32'(pos_inc);

  always_comb begin
    if (last_byte) begin
      pos_next = '0;
    end else if (at_limit) begin
      pos_next = pos;
    end else begin
      pos_next = pos_inc;
    end
  end

  pfl_step u_step (
    .state            (state),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .at_limit         (at_limit),
    .next_offset      (pos_wide[pfl_pkg::OFFSET_W-1:0]),
    .seek_field       (seek_field),
    .target_wire_type (target_wire_type),
    .state_next       (state_next),
    .res_valid        (step_valid),
    .result           (step_result)
  );

  // scan state advances on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfl_pkg::STATE_IDLE;
      pos   <= '0;
    end else if (accept) begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  // result register control: skid drains first, new request goes to skid
  // only while the result register is held
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (pop || !result_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= step_result;
      end
    end else if (push) begin
      skid_data <= step_result;
    end
  end

  assign found          = out_data.found;
  assign content_offset = out_data.content_offset;
  assign field_length   = out_data.field_length;

  // skid holds a request only behind a held result register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid entry occupied with empty result register");

  // the last byte of an unanswered buffer always yields a request
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte && (state.phase != pfl_pkg::PH_DONE)) |=> result_valid)
    else $error("no request for closing byte of unanswered buffer");

  // last byte returns scan to its start
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> ((state.phase == pfl_pkg::PH_KEY) && (pos == '0)))
    else $error("scan not restarted after last byte");

  // byte position never passes the buffer limit
  assert property (@(posedge clk) disable iff (rst) pos <= POS_W'(MAX_BUFFER_BYTES))
    else $error("byte position beyond buffer limit");

endmodule

@@ dv/pfl_scan_checker.sv @@
module pfl_scan_checker
  import pfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic                byte_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic                found,
  input  logic [OFFSET_W-1:0] content_offset,
  input  logic [LENGTH_W-1:0] field_length,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output int                  fail_count,
  output int                  answers_waiting,
  output int                  answers_checked,
  output int                  hits_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // target registers as the block should hold them
  logic [FIELD_W-1:0]  want_field;
  logic [WTYPE_W-1:0]  want_wt;

  // per-buffer scan state
  phase_t              scan_ph;
  int unsigned         scan_pos;
  logic [LENGTH_W-1:0] vacc;
  int unsigned         vshift;
  logic [WTYPE_W-1:0]  key_wt;
  logic                key_hit;
  logic [LENGTH_W-1:0] skip_left;
  logic [OFFSET_W-1:0] hit_ofs;
  logic                answered;

  pfl_result_t         answer_q[$];
  int                  fails;
  int                  checked;
  int                  hits;

  task automatic clear_scan();
    scan_ph   = PH_KEY;
    scan_pos  = 0;
    vacc      = '0;
    vshift    = 0;
    key_wt    = '0;
    key_hit   = 1'b0;
    skip_left = '0;
    hit_ofs   = '0;
    answered  = 1'b0;
  endtask

  task automatic restart(input phase_t nxt);
    vacc    = '0;
    vshift  = 0;
    scan_ph = nxt;
  endtask

  task automatic answer(input logic hit, input logic [OFFSET_W-1:0] ofs,
                        input logic [LENGTH_W-1:0] len);
    pfl_result_t r;
    r.found          = hit;
    r.content_offset = hit ? ofs : '0;
    r.field_length   = hit ? len : '0;
    answer_q.push_back(r);
    answered = 1'b1;
    scan_ph  = PH_DONE;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    int unsigned         pos;
    logic [LENGTH_W-1:0] v;
    logic                overlong;
    pos      = scan_pos;
    overlong = 1'b0;
    if (pos < MAX_BUFFER_BYTES) scan_pos = pos + 1;
    if (!answered && pos >= MAX_BUFFER_BYTES) begin
      answer(1'b0, '0, '0);
    end else if (scan_ph == PH_KEY || scan_ph == PH_VALUE || scan_ph == PH_LEN) begin
      if (vshift < 64) vacc |= 64'(b[6:0]) << vshift;
      if (b[7]) begin
        vshift += 7;
        overlong = (vshift >= 64);
      end
      if (overlong) begin
        answer(1'b0, '0, '0);
      end else if (!b[7]) begin
        v = vacc;
        case (scan_ph)
          PH_KEY: begin
            key_wt  = v[2:0];
            key_hit = (v[34:3] == want_field) && (v[2:0] == want_wt);
            if (key_wt == WT_VARINT) begin
              hit_ofs = 16'(pos + 1);
              restart(PH_VALUE);
            end else if (key_wt == WT_LEN) begin
              restart(PH_LEN);
            end else if (key_wt == WT_I64 || key_wt == WT_I32) begin
              key_hit   = 1'b0;
              skip_left = (key_wt == WT_I64) ? 64'd8 : 64'd4;
              scan_ph   = PH_SKIP;
            end else begin
              answer(1'b0, '0, '0);
            end
          end
          PH_VALUE: begin
            if (key_hit) answer(1'b1, hit_ofs, v);
            else restart(PH_KEY);
          end
          default: begin
            hit_ofs = 16'(pos + 1);
            if (v == '0) begin
              if (key_hit) answer(1'b1, hit_ofs, '0);
              else restart(PH_KEY);
            end else begin
              skip_left = v;
              scan_ph   = PH_SKIP;
            end
          end
        endcase
      end
    end else if (scan_ph == PH_SKIP) begin
      skip_left -= 1;
      if (skip_left == '0) begin
        if (key_hit) answer(1'b1, hit_ofs, vacc);
        else restart(PH_KEY);
      end
    end
    if (last) begin
      if (!answered) answer(1'b0, '0, '0);
      clear_scan();
    end
  endtask

  task automatic compare_answer();
    pfl_result_t e;
    checked++;
    if (answer_q.size() == 0) begin
      fails++;
      $display("%0t: answer with none expected: found=%0b offset=%0d length=%0h",
               $time, found, content_offset, field_length);
    end else begin
      e = answer_q.pop_front();
      if (e.found) hits++;
      if (found !== e.found) begin
        fails++;
        $display("%0t: found expected %0b actual %0b", $time, e.found, found);
      end
      if (content_offset !== e.content_offset) begin
        fails++;
        $display("%0t: content_offset expected %0d actual %0d",
                 $time, e.content_offset, content_offset);
      end
      if (field_length !== e.field_length) begin
        fails++;
        $display("%0t: field_length expected %0h actual %0h",
                 $time, e.field_length, field_length);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_field = TARGET_FIELD_RESET;
      want_wt    = TARGET_WIRE_TYPE_RESET;
      clear_scan();
      answer_q.delete();
    end else begin
      if (result_valid && !result_stall) compare_answer();
      if (cfg_write) begin
        if (cfg_index == CFG_TARGET_FIELD) want_field = cfg_data[FIELD_W-1:0];
        else want_wt = cfg_data[WTYPE_W-1:0];
      end
      if (byte_valid && !byte_stall) scan_byte(data_byte, last_byte);
    end
    fail_count      <= fails;
    answers_waiting <= answer_q.size();
    answers_checked <= checked;
    hits_checked    <= hits;
  end

endmodule

@@ dv/tb_protobuf_field_locator.sv @@
module tb_protobuf_field_locator;
  import pfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // wire types that the package leaves unnamed: groups and reserved codes
  localparam logic [WTYPE_W-1:0] WT_GROUP_START = 3'd3;
  localparam logic [WTYPE_W-1:0] WT_GROUP_END   = 3'd4;
  localparam logic [WTYPE_W-1:0] WT_RSVD6       = 3'd6;
  localparam logic [WTYPE_W-1:0] WT_RSVD7       = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  logic [7:0]          data_byte = '0;
  logic                last_byte = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                found;
  logic [OFFSET_W-1:0] content_offset;
  logic [LENGTH_W-1:0] field_length;
  logic                cfg_write = 1'b0;
  logic                cfg_index = CFG_TARGET_FIELD;
  logic [CFG_W-1:0]    cfg_data = '0;

  int fail_count;
  int answers_waiting;
  int answers_checked;
  int hits_checked;

  // stimulus bookkeeping
  logic [7:0]         frame_q[$];
  logic [FIELD_W-1:0] cur_field = TARGET_FIELD_RESET;
  logic [WTYPE_W-1:0] cur_wt    = TARGET_WIRE_TYPE_RESET;
  int                 burst_left = 0;
  int                 bytes_sent = 0;
  int                 frames_sent = 0;
  int                 settings_used = 1;

  always #5 clk = ~clk;

  protobuf_field_locator dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .content_offset (content_offset),
    .field_length   (field_length),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // watches both channels and the register port, predicts every answer
  pfl_scan_checker scan_check (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .found           (found),
    .content_offset  (content_offset),
    .field_length    (field_length),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .answers_waiting (answers_waiting),
    .answers_checked (answers_checked),
    .hits_checked    (hits_checked)
  );

  // append a varint; extra adds non-minimal continuation groups,
  // dirty fills the bits of a tenth byte that fall past bit 63,
  // overlong emits ten continuation bytes and a stray terminator
  task automatic put_varint(input logic [63:0] v, input int extra,
                            input bit dirty, input bit overlong);
    int          n;
    logic [63:0] rest;
    logic [7:0]  b;
    n    = 1;
    rest = v >> 7;
    while (rest != 0) begin
      n++;
      rest = rest >> 7;
    end
    n += extra;
    if (n > 10) n = 10;
    if (overlong) n = 11;
    for (int i = 0; i < n; i++) begin
      b[6:0] = overlong ? 7'($urandom) : 7'(v >> (i * 7));
      if (i == 9 && dirty && !overlong) b[6:1] = 6'($urandom);
      b[7] = (i < n - 1);
      frame_q.push_back(b);
    end
  endtask

  // build one buffer: mostly well-formed field sequences around the
  // current target, some truncated, some with junk, a few pure noise
  task automatic make_frame();
    int                 kind, sel, nf, len, cut;
    logic [FIELD_W-1:0] fnum;
    logic [WTYPE_W-1:0] wt;
    logic [28:0]        alias_bits;
    logic [63:0]        v;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
    end else begin
      nf = $urandom_range(0, 5);
      repeat (nf) begin
        // field number: target, near miss, small or wide
        sel = $urandom_range(0, 99);
        if (sel < 50) fnum = cur_field;
        else if (sel < 65) fnum = cur_field ^ (32'd1 << $urandom_range(0, 31));
        else if (sel < 85) fnum = $urandom_range(0, 31);
        else fnum = $urandom;
        // wire type: target, common kinds, group or reserved
        sel = $urandom_range(0, 99);
        if (sel < 35) wt = cur_wt;
        else if (sel < 60) wt = WT_VARINT;
        else if (sel < 80) wt = WT_LEN;
        else if (sel < 88) wt = WT_I64;
        else if (sel < 95) wt = WT_I32;
        else begin
          case ($urandom_range(0, 3))
            0: wt = WT_GROUP_START;
            1: wt = WT_GROUP_END;
            2: wt = WT_RSVD6;
            default: wt = WT_RSVD7;
          endcase
        end
        // key bits above the field number are dropped by the block
        alias_bits = ($urandom_range(0, 9) == 0) ? 29'($urandom) : '0;
        put_varint({alias_bits, fnum, wt}, ($urandom_range(0, 4) == 0) ?
                   $urandom_range(1, 9) : 0, $urandom_range(0, 1),
                   $urandom_range(0, 59) == 0);
        case (wt)
          WT_VARINT: begin
            v = {$urandom, $urandom};
            sel = $urandom_range(0, 64);
            if (sel < 64) v = v & ((64'd1 << sel) - 1);
            put_varint(v, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0,
                       $urandom_range(0, 1), $urandom_range(0, 39) == 0);
          end
          WT_LEN: begin
            sel = $urandom_range(0, 99);
            if (sel < 70) v = $urandom_range(0, 6);
            else if (sel < 90) v = $urandom_range(7, 24);
            else if (sel < 97) v = $urandom_range(25, 300);
            else v = {$urandom, $urandom};
            put_varint(v, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0,
                       $urandom_range(0, 1), $urandom_range(0, 39) == 0);
            len = (v > 300) ? $urandom_range(0, 8) : int'(v);
            repeat (len) frame_q.push_back(8'($urandom));
          end
          WT_I64: repeat (8) frame_q.push_back(8'($urandom));
          WT_I32: repeat (4) frame_q.push_back(8'($urandom));
          default: ;
        endcase
      end
      // cut short inside some element
      if (kind >= 80 && kind < 90 && frame_q.size() > 1) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        frame_q = frame_q[0:cut-1];
      end
      // trailing junk
      if (kind >= 90) repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    end
    if (frame_q.size() == 0) frame_q.push_back(8'($urandom));
  endtask

  // one request on the byte channel, sender runs in bursts with gaps
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 24);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // hold the sender until every outstanding answer has been taken
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (answers_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers back to back, upper data bits of the wire type random
  task automatic set_target(input logic [FIELD_W-1:0] fnum, input logic [WTYPE_W-1:0] wt);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TARGET_FIELD;
    cfg_data  <= fnum;
    @(posedge clk);
    cfg_index <= CFG_TARGET_WIRE_TYPE;
    cfg_data  <= {29'($urandom), wt};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_field = fnum;
    cur_wt    = wt;
    settings_used++;
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      make_frame();
      send_frame();
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();
  endtask

  // receiver: stall pattern switches among four modes
  initial begin
    int mode, span, cnt;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 300);
      cnt  = 0;
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ((cnt % 23) < 20);
        endcase
        cnt++;
      end
    end
  end

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset targets (field 1, delimited)
    frame_q = '{8'h0A, 8'h00};                        // empty delimited hit
    send_frame();
    frame_q = '{8'h0D, 8'h00, 8'hFF, 8'h80, 8'h7F,    // fixed32 named by target
                8'h0A, 8'h01, 8'hFF};                 // then one-byte hit
    send_frame();
    frame_q = '{8'h0B};                               // group start
    send_frame();
    frame_q = '{8'h0A, 8'h05, 8'h01};                 // content cut short
    send_frame();
    frame_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80,    // key never ends
                8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
    send_frame();
    drain();

    random_phase(250);
    set_target(32'd1, WT_VARINT);
    random_phase(300);
    set_target(32'd0, WT_VARINT);
    random_phase(250);
    set_target(32'hFFFF_FFFF, WT_LEN);
    random_phase(250);
    set_target($urandom, WT_I64);
    random_phase(200);
    set_target($urandom_range(0, 15), WT_RSVD7);
    random_phase(200);
    set_target($urandom, WT_I32);
    random_phase(200);
    random_phase(300);

    repeat (8) @(posedge clk);
    $display("scanned %0d buffers, %0d bytes, under %0d target settings",
             frames_sent, bytes_sent, settings_used);
    $display("%0d answers compared, %0d of them hits", answers_checked, hits_checked);
    if (fail_count == 0 && answers_waiting == 0) begin
      $display("tb_protobuf_field_locator OK");
    end else begin
      $display("tb_protobuf_field_locator NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #200ms;
    $display("timeout with %0d answers outstanding", answers_waiting);
    $display("tb_protobuf_field_locator NOT OK");
    $finish;
  end

endmodule
